// ===== hw/rtl/clipped_glyph_row_blitter_unit_macros.svh =====
// Assertion macros shared by the glyph blitter RTL.
// Expects clk and arst_n in the scope of every use.
`ifndef CLIPPED_GLYPH_ROW_BLITTER_UNIT_MACROS_SVH
`define CLIPPED_GLYPH_ROW_BLITTER_UNIT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define CGRB_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define CGRB_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CGRB_ASSERT_IMP(name, ante, cons, msg)
`define CGRB_ASSERT_NXT(name, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/cgrb_pkg.sv =====
// Shared types, constants and codes of the clipped glyph row blitter.
// No dependencies; every RTL module and interface imports this package.
`default_nettype none

package cgrb_pkg;

	// font store geometry
	localparam int PLANES     = 4;
	localparam int MAX_ROWS   = 16;
	localparam int GLYPHS     = 256;
	localparam int FONT_DEPTH = GLYPHS * MAX_ROWS;
	localparam int ADDR_W     = (FONT_DEPTH > 1) ? $clog2(FONT_DEPTH) : 1;
	localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int RCNT_W     = $clog2(MAX_ROWS + 1);
	localparam int SLOT_W     = (GLYPHS > 1) ? $clog2(GLYPHS) : 1;

	// signed width of the clip geometry arithmetic
	localparam int GEO_W = 18;

	localparam logic [3:0] PLANE_MASK = 4'((1 << PLANES) - 1);

	// operation codes
	localparam logic OP_DRAW = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEFT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLIP_TOP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLIP_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CLIP_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CHAR  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_CHAR   = 3'd7;

	typedef struct packed {
		logic [11:0] clip_left;
		logic [11:0] clip_top;
		logic [11:0] clip_width;
		logic [11:0] clip_height;
		logic [4:0]  cell_width;
		logic [4:0]  cell_height;
		logic [7:0]  first_char;
		logic [7:0]  last_char;
	} cgrb_cfg_t;

	localparam cgrb_cfg_t CFG_RESET = '{
		clip_left:   12'd0,
		clip_top:    12'd0,
		clip_width:  12'd320,
		clip_height: 12'd200,
		cell_width:  5'd8,
		cell_height: 5'd8,
		first_char:  8'd32,
		last_char:   8'd127
	};

	// input request
	typedef struct packed {
		logic               operation;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [7:0]         char_code;
		logic [3:0]         colour;
		logic [3:0]         load_row;
		logic [15:0]        load_bits;
	} cgrb_req_t;

	// output request
	typedef struct packed {
		logic [11:0] screen_row;
		logic [7:0]  word_column;
		logic [15:0] pixel_mask;
		logic [3:0]  pixel_colour;
		logic        last;
	} cgrb_res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_GEOM,
		ST_MASK,
		ST_START,
		ST_SPLIT,
		ST_HI,
		ST_LO,
		ST_FLUSH
	} cgrb_state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic font_wr;
		logic check;
		logic geom;
		logic mask;
		logic start;
		logic split;
		logic push_hi;
		logic push_lo;
		logic flush;
	} cgrb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic reject;
		logic split_hi;
		logic split_lo;
		logic split_more;
		logic held_lo;
		logic held_more;
		logic can_push;
		logic out_free;
		logic pend_v;
	} cgrb_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cgrb_req_if.sv =====
// Input channel of the glyph blitter: valid/ready with a request payload.
// Depends on cgrb_pkg.
`default_nettype none

interface cgrb_req_if;
	import cgrb_pkg::*;

	logic      valid;
	logic      ready;
	cgrb_req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cgrb_res_if.sv =====
// Output channel of the glyph blitter: valid/ready with a result payload.
// Depends on cgrb_pkg.
`default_nettype none

interface cgrb_res_if;
	import cgrb_pkg::*;

	logic      valid;
	logic      ready;
	cgrb_res_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cgrb_ctrl.sv =====
// Sequencing state machine of the glyph blitter.
// Depends on cgrb_pkg; drives the datapath through cgrb_cmd_t.
`default_nettype none

module cgrb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_op,
	output logic               in_ready,
	output cgrb_pkg::cgrb_cmd_t cmd,
	input  cgrb_pkg::cgrb_sts_t sts
);
	import cgrb_pkg::*;

	cgrb_state_t state_q;
	cgrb_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_op == OP_DRAW) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: state_d = ST_GEOM;
			ST_GEOM:  state_d = ST_MASK;
			ST_MASK:  state_d = ST_START;
			ST_START: begin
				state_d = sts.reject ? ST_IDLE : ST_SPLIT;
			end
			ST_SPLIT: begin
				if (sts.split_hi) begin
					state_d = ST_HI;
				end else if (sts.split_lo) begin
					state_d = ST_LO;
				end else if (sts.split_more) begin
					state_d = ST_SPLIT;
				end else begin
					state_d = ST_FLUSH;
				end
			end
			ST_HI: begin
				if (sts.can_push) begin
					if (sts.held_lo) begin
						state_d = ST_LO;
					end else if (sts.held_more) begin
						state_d = ST_SPLIT;
					end else begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_LO: begin
				if (sts.can_push) begin
					state_d = sts.held_more ? ST_SPLIT : ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!sts.pend_v || sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				cmd.font_wr = in_valid && in_op == OP_LOAD;
			end
			ST_CHECK: cmd.check   = 1'b1;
			ST_GEOM:  cmd.geom    = 1'b1;
			ST_MASK:  cmd.mask    = 1'b1;
			ST_START: cmd.start   = !sts.reject;
			ST_SPLIT: cmd.split   = 1'b1;
			ST_HI:    cmd.push_hi = sts.can_push;
			ST_LO:    cmd.push_lo = sts.can_push;
			ST_FLUSH: cmd.flush   = sts.pend_v && sts.out_free;
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/cgrb_datapath.sv =====
// Datapath of the glyph blitter: font store, clip geometry, row split
// and the pending/output request registers. Depends on cgrb_pkg.
`default_nettype none
`include "clipped_glyph_row_blitter_unit_macros.svh"

module cgrb_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  cgrb_pkg::cgrb_cfg_t cfg,
	input  cgrb_pkg::cgrb_req_t req_data,
	input  cgrb_pkg::cgrb_cmd_t cmd,
	output cgrb_pkg::cgrb_sts_t sts,
	output logic                res_valid,
	output cgrb_pkg::cgrb_res_t res_data,
	input  logic                res_ready
);
	import cgrb_pkg::*;

	// font store
	logic [15:0]       font_mem [FONT_DEPTH];
	logic [15:0]       rd_data_q;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic [RCNT_W-1:0] rd_row;
	logic              wr_en;
	logic              rd_en;

	// captured draw request
	logic [15:0] x_q;
	logic [15:0] y_q;
	logic [7:0]  code_q;
	logic [3:0]  colour_q;

	// clip geometry
	logic [SLOT_W-1:0]        slot_q;
	logic                     rej_q;
	logic signed [GEO_W-1:0]  cl_q;
	logic signed [GEO_W-1:0]  cr_q;
	logic signed [GEO_W-1:0]  xr_q;
	logic signed [GEO_W-1:0]  re_q;
	logic signed [GEO_W-1:0]  d0_q;
	logic signed [GEO_W-1:0]  d1_q;
	logic signed [GEO_W-1:0]  bot_q;
	logic [4:0]               rows_q;
	logic [15:0]              mask_q;
	logic [RCNT_W-1:0]        row0_q;
	logic [RCNT_W-1:0]        row1_q;

	logic signed [GEO_W-1:0] x_ext;
	logic signed [GEO_W-1:0] y_ext;
	logic signed [GEO_W-1:0] cw_s;
	logic signed [GEO_W-1:0] left_ext;
	logic signed [GEO_W-1:0] top_ext;
	logic signed [GEO_W-1:0] width_ext;
	logic signed [GEO_W-1:0] height_ext;
	logic signed [GEO_W-1:0] rows_ext;
	logic signed [GEO_W-1:0] r0_full;
	logic signed [GEO_W-1:0] r1_full;
	logic [7:0]              slot_full;
	logic                    code_bad;
	logic                    cw_bad;
	logic                    slot_far;
	logic                    cl_pos;
	logic                    cr_pos;
	logic                    d0_pos;
	logic [5:0]              sh_base;
	logic [5:0]              sh_right;
	logic [15:0]             base_mask;
	logic [15:0]             left_mask;
	logic [15:0]             right_mask;

	// row loop
	logic [RCNT_W-1:0] r_q;
	logic [RCNT_W-1:0] r_next;
	logic [15:0]       row_bits;
	logic [31:0]       row_wide;
	logic [15:0]       hi_q;
	logic [15:0]       lo_q;
	logic              lo_nz_q;
	logic              more_q;
	logic [11:0]       srow_q;
	logic              more_now;

	// pending word and output register
	logic        pend_v_q;
	logic [11:0] pend_row_q;
	logic [7:0]  pend_col_q;
	logic [15:0] pend_mask_q;
	logic        out_valid_q;
	cgrb_res_t   out_res_q;
	logic        out_free;
	logic        can_push;
	logic        push;
	logic        load_out;
	logic [7:0]  col_lo;

	// font store ports
	assign wr_en   = cmd.font_wr
		&& ({1'b0, req_data.char_code} < 9'(GLYPHS))
		&& ({1'b0, req_data.load_row} < 5'(MAX_ROWS));
	assign wr_addr = ADDR_W'(req_data.char_code) * ADDR_W'(MAX_ROWS)
		+ ADDR_W'(req_data.load_row);
	assign r_next  = RCNT_W'(r_q + 1'b1);
	assign rd_row  = cmd.start ? row0_q : r_next;
	assign rd_en   = cmd.start || (cmd.split && more_now);
	assign rd_addr = ADDR_W'(slot_q) * ADDR_W'(MAX_ROWS) + ADDR_W'(rd_row[ROW_W-1:0]);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			font_mem[wr_addr] <= req_data.load_bits;
		end
		if (rd_en) begin
			rd_data_q <= font_mem[rd_addr];
		end
	end

	// operand extension
	assign x_ext      = {{(GEO_W-16){x_q[15]}}, x_q};
	assign y_ext      = {{(GEO_W-16){y_q[15]}}, y_q};
	assign cw_s       = {{(GEO_W-5){1'b0}}, cfg.cell_width};
	assign left_ext   = {{(GEO_W-12){1'b0}}, cfg.clip_left};
	assign top_ext    = {{(GEO_W-12){1'b0}}, cfg.clip_top};
	assign width_ext  = {{(GEO_W-12){1'b0}}, cfg.clip_width};
	assign height_ext = {{(GEO_W-12){1'b0}}, cfg.clip_height};
	assign rows_ext   = {{(GEO_W-5){1'b0}}, rows_q};

	// code and cell checks
	assign slot_full = code_q - cfg.first_char;
	assign code_bad  = (code_q < cfg.first_char) || (code_q > cfg.last_char);
	assign slot_far  = {1'b0, slot_full} >= 9'(GLYPHS);
	assign cw_bad    = (cfg.cell_width == 5'd0) || (cfg.cell_width > 5'd16);

	// horizontal mask pieces; shifts only matter when the cell is not rejected
	assign cl_pos     = !cl_q[GEO_W-1] && (cl_q != '0);
	assign cr_pos     = !cr_q[GEO_W-1] && (cr_q != '0);
	assign sh_base    = 6'd16 - {1'b0, cfg.cell_width};
	assign sh_right   = sh_base + {1'b0, cr_q[4:0]};
	assign base_mask  = 16'hFFFF << sh_base;
	assign left_mask  = cl_pos ? (16'hFFFF >> cl_q[4:0]) : 16'hFFFF;
	assign right_mask = cr_pos ? (16'hFFFF << sh_right) : 16'hFFFF;

	// vertical row range
	assign d0_pos  = !d0_q[GEO_W-1] && (d0_q != '0);
	assign r0_full = d0_pos ? d0_q : '0;
	assign r1_full = (rows_ext > d1_q) ? d1_q : rows_ext;

	// capture and setup steps
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q      <= req_data.pos_x;
			y_q      <= req_data.pos_y;
			code_q   <= req_data.char_code;
			colour_q <= req_data.colour;
		end
		if (cmd.check) begin
			rej_q  <= cw_bad || code_bad || slot_far;
			slot_q <= slot_full[SLOT_W-1:0];
			cl_q   <= left_ext - x_ext;
			xr_q   <= x_ext + cw_s;
			re_q   <= left_ext + width_ext;
			d0_q   <= top_ext - y_ext;
			bot_q  <= top_ext + height_ext;
		end
		if (cmd.geom) begin
			cr_q   <= xr_q - re_q;
			d1_q   <= bot_q - y_ext;
			rej_q  <= rej_q || (cl_q >= cw_s);
			rows_q <= (cfg.cell_height > 5'(MAX_ROWS)) ? 5'(MAX_ROWS) : cfg.cell_height;
		end
		if (cmd.mask) begin
			rej_q  <= rej_q || (cr_q >= cw_s) || (r0_full >= r1_full);
			mask_q <= base_mask & left_mask & right_mask;
			row0_q <= r0_full[RCNT_W-1:0];
			row1_q <= r1_full[RCNT_W-1:0];
		end
	end

	// split one glyph row across two screen words
	assign row_bits = rd_data_q & mask_q;
	assign row_wide = {row_bits, 16'h0000} >> x_q[3:0];
	assign more_now = r_next < row1_q;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			r_q <= row0_q;
		end else if (cmd.split) begin
			r_q     <= r_next;
			hi_q    <= row_wide[31:16];
			lo_q    <= row_wide[15:0];
			lo_nz_q <= row_wide[15:0] != 16'h0000;
			more_q  <= more_now;
			srow_q  <= y_q[11:0] + 12'(r_q);
		end
	end

	// pending word: held back one step so the final request can carry last
	assign out_free = !out_valid_q || res_ready;
	assign can_push = !pend_v_q || out_free;
	assign push     = cmd.push_hi || cmd.push_lo;
	assign load_out = (push && pend_v_q) || cmd.flush;
	assign col_lo   = x_q[11:4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (push) begin
				pend_v_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_v_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			pend_row_q  <= srow_q;
			pend_col_q  <= cmd.push_hi ? col_lo : col_lo + 8'd1;
			pend_mask_q <= cmd.push_hi ? hi_q : lo_q;
		end
		if (load_out) begin
			out_res_q.screen_row   <= pend_row_q;
			out_res_q.word_column  <= pend_col_q;
			out_res_q.pixel_mask   <= pend_mask_q;
			out_res_q.pixel_colour <= colour_q & PLANE_MASK;
			out_res_q.last         <= cmd.flush;
		end
	end

	// status back to the controller
	always_comb begin
		sts            = '0;
		sts.reject     = rej_q || (mask_q == 16'h0000);
		sts.split_hi   = row_wide[31:16] != 16'h0000;
		sts.split_lo   = row_wide[15:0] != 16'h0000;
		sts.split_more = more_now;
		sts.held_lo    = lo_nz_q;
		sts.held_more  = more_q;
		sts.can_push   = can_push;
		sts.out_free   = out_free;
		sts.pend_v     = pend_v_q;
	end

	assign res_valid = out_valid_q;
	assign res_data  = out_res_q;

	// a push over a held word must find the output register free
	`CGRB_ASSERT_IMP(a_push_room, push && pend_v_q, out_free, "pending word overwritten")
	// flushing leaves the final request, flagged last, in the output register
	`CGRB_ASSERT_NXT(a_flush_last, cmd.flush, !pend_v_q && out_valid_q && out_res_q.last, "flush lost")
	// rows are only split inside the clipped range
	`CGRB_ASSERT_IMP(a_row_range, cmd.split, r_q < row1_q, "row beyond clip range")
	// a new item never starts with a word of the previous one held back
	`CGRB_ASSERT_IMP(a_clean_start, cmd.capture, !pend_v_q, "word left pending at new item")

endmodule

`default_nettype wire

// ===== hw/rtl/clipped_glyph_row_blitter_unit.sv =====
// Clipped glyph row blitter, top level: configuration registers, controller
// and datapath. Depends on cgrb_pkg, cgrb_req_if, cgrb_res_if and the submodules.
//
// Takes load and draw requests on req and returns word-mask requests on res.
// A load writes one 16-bit row into the 4096-entry font store and leaves
// the controller idle; the store has no reset, so only loaded rows may be
// drawn. A draw runs the code check, the horizontal and vertical clip and a
// start step, then for each visible glyph row reads the font store, splits
// the row across two screen words and writes each nonzero word out, waiting
// while the output register is full, then releases the final request with
// last set. The single font store read port and the one-word output register
// set its pace. A rejected or fully clipped draw returns to accepting after
// the start step with no result. The output register lets the next request
// start while the last result of the previous one still waits. Configuration
// must be written through cfg_we, cfg_index and cfg_data only while no draw
// is in progress; the block itself does not enforce this.
`default_nettype none

module clipped_glyph_row_blitter_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [cgrb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cgrb_pkg::CFG_DATA_W-1:0]   cfg_data,
	cgrb_req_if.sink                          req,
	cgrb_res_if.source                        res
);
	import cgrb_pkg::*;

	cgrb_cfg_t cfg_q;
	cgrb_cmd_t cmd;
	cgrb_sts_t sts;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CLIP_LEFT:   cfg_q.clip_left   <= cfg_data;
				CFG_CLIP_TOP:    cfg_q.clip_top    <= cfg_data;
				CFG_CLIP_WIDTH:  cfg_q.clip_width  <= cfg_data;
				CFG_CLIP_HEIGHT: cfg_q.clip_height <= cfg_data;
				CFG_CELL_WIDTH:  cfg_q.cell_width  <= cfg_data[4:0];
				CFG_CELL_HEIGHT: cfg_q.cell_height <= cfg_data[4:0];
				CFG_FIRST_CHAR:  cfg_q.first_char  <= cfg_data[7:0];
				CFG_LAST_CHAR:   cfg_q.last_char   <= cfg_data[7:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// sequencing
	cgrb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_op    (req.payload.operation),
		.in_ready (req.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// datapath and font store
	cgrb_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req_data  (req.payload),
		.cmd       (cmd),
		.sts       (sts),
		.res_valid (res.valid),
		.res_data  (res.payload),
		.res_ready (res.ready)
	);

endmodule

`default_nettype wire
